/* sv/rts_pkg.sv */
package rts_pkg;

	// Queue between the classifier and the tally
	localparam int FIFO_DEPTH = 4;

	// Fixed widths of the result fields, the syllable and group counters and the code point
	localparam int OUT_CNT_W = 24;
	localparam int EASE_W    = 14;
	localparam int GRADE_W   = 32;
	localparam int SYL_W     = 32;
	localparam int GROUP_W   = 16;
	localparam int CP_W      = 21;

	// Scaled Flesch coefficients (hundredths; the ease terms doubled for the half-unit base)
	localparam int EASE_BASE = 41367;
	localparam int EASE_WW   = 203;
	localparam int EASE_YS   = 16920;
	localparam int GRADE_WW  = 39;
	localparam int GRADE_YS  = 1180;
	localparam int GRADE_SW  = 1559;
	localparam int EASE_TOP  = 10000;
	localparam logic [GRADE_W-1:0] GRADE_TOP = '1;

	// Character codes with a role of their own
	localparam logic [CP_W-1:0] CP_NEWLINE    = 21'h00000A;
	localparam logic [CP_W-1:0] CP_FULL_STOP  = 21'h00002E;
	localparam logic [CP_W-1:0] CP_EXCLAIM    = 21'h000021;
	localparam logic [CP_W-1:0] CP_QUESTION   = 21'h00003F;
	localparam logic [CP_W-1:0] CP_UNDERSCORE = 21'h00005F;
	localparam logic [CP_W-1:0] CP_DOT_I_CAP  = 21'h000130;

	typedef struct packed {
		logic has_char;
		logic last;
		logic space;
		logic newline;
		logic punct;
		logic letter;
		logic wordc;
		logic vowel;
		logic is_e;
	} char_class_t;

endpackage

/* sv/rts_in_if.sv */
interface rts_in_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        has_char;
	logic        last;

	modport source (output valid, code_point, has_char, last, input ready);
	modport sink (input valid, code_point, has_char, last, output ready);
endinterface

/* sv/rts_out_if.sv */
interface rts_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] nonblank_lines;
	logic [23:0] word_total;
	logic [23:0] visible_chars;
	logic [23:0] sentence_total;
	logic [13:0] reading_ease_x100;
	logic [31:0] grade_level_x100;

	modport source (output valid, nonblank_lines, word_total, visible_chars, sentence_total,
		reading_ease_x100, grade_level_x100, input ready);
	modport sink (input valid, nonblank_lines, word_total, visible_chars, sentence_total,
		reading_ease_x100, grade_level_x100, output ready);
endinterface

/* sv/readability_text_stats.sv */
// Channel   Direction  Payload                                          Transfer
// in_ch     sink       code_point[20:0], has_char, last                 valid && ready
// out_ch    source     nonblank_lines, word_total, visible_chars,       valid && ready
//                      sentence_total, reading_ease_x100, grade_level_x100
//
// Characters: one transfer per cycle while the queue has room; the classifier feeds a
// four-entry queue and the tally drains one entry per cycle, bar a last item held while
// the scorer is busy. End of text: the scorer runs S_MUL and S_SCALE, then for each score
// S_PREP, a bit-serial divide in S_DIV (skipped if not positive) and S_FIN.
// Meanwhile the tally keeps working on the next text until it meets another last item.
// Reset: arst_n clears all counters, the queue and the scorer at once.
// Stalls: a held result blocks the scorer, then the tally; the queue takes input until full.
module readability_text_stats #(
	parameter int COUNT_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	rts_in_if.sink    in_ch,
	rts_out_if.source out_ch
);
	import rts_pkg::*;

	char_class_t           push_data;
	char_class_t           head;
	logic                  push, pop, full, empty;
	logic                  done_valid, done_ready;
	logic [COUNT_BITS-1:0] fin_lines, fin_words, fin_chars, fin_sents;
	logic [SYL_W-1:0]      fin_syl;

	// classify each code point as it is transferred in
	rts_front u_front (
		.in_ch     (in_ch),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// hold classified characters so front and back stall apart
	rts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	// advance the counters; hand totals over on the last item
	rts_tally #(.COUNT_BITS(COUNT_BITS)) u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.fin_lines  (fin_lines),
		.fin_words  (fin_words),
		.fin_chars  (fin_chars),
		.fin_sents  (fin_sents),
		.fin_syl    (fin_syl)
	);

	// work out both scores and hold the result until it is taken
	rts_score #(.COUNT_BITS(COUNT_BITS)) u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (done_valid),
		.start_ready (done_ready),
		.fin_lines   (fin_lines),
		.fin_words   (fin_words),
		.fin_chars   (fin_chars),
		.fin_sents   (fin_sents),
		.fin_syl     (fin_syl),
		.out_ch      (out_ch)
	);
endmodule

/* sv/rts_front.sv */
module rts_front (
	rts_in_if.sink              in_ch,
	input  logic                full,
	output logic                push,
	output rts_pkg::char_class_t push_data
);
	import rts_pkg::*;

	logic [CP_W-1:0] c;

	assign c            = in_ch.code_point;
	assign in_ch.ready  = !full;
	assign push         = in_ch.valid && !full;

	always_comb begin
		push_data          = '0;
		push_data.has_char = in_ch.has_char;
		push_data.last     = in_ch.last;
		push_data.space    = c inside {[21'h09:21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680,
			[21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};
		push_data.newline  = (c == CP_NEWLINE);
		push_data.punct    = c inside {CP_FULL_STOP, CP_EXCLAIM, CP_QUESTION};
		push_data.letter   = c inside {[21'h41:21'h5A], [21'h61:21'h7A], 21'hC7, 21'hD6, 21'hDC,
			21'hE7, 21'hF6, 21'hFC, 21'h11E, 21'h11F, CP_DOT_I_CAP, 21'h131, 21'h15E, 21'h15F};
		push_data.wordc    = push_data.letter || (c inside {[21'h30:21'h39]})
			|| (c == CP_UNDERSCORE);
		push_data.vowel    = c inside {21'h61, 21'h65, 21'h69, 21'h6F, 21'h75, 21'h79,
			21'h41, 21'h45, 21'h49, 21'h4F, 21'h55, 21'h59, CP_DOT_I_CAP};
		push_data.is_e     = c inside {21'h65, 21'h45};
	end
endmodule

/* sv/rts_fifo.sv */
module rts_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rts_pkg::char_class_t push_data,
	input  logic                 pop,
	output rts_pkg::char_class_t head,
	output logic                 full,
	output logic                 empty
);
	import rts_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	char_class_t      mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* sv/rts_tally.sv */
module rts_tally #(
	parameter int COUNT_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rts_pkg::char_class_t       head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       done_valid,
	input  logic                       done_ready,
	output logic [COUNT_BITS-1:0]      fin_lines,
	output logic [COUNT_BITS-1:0]      fin_words,
	output logic [COUNT_BITS-1:0]      fin_chars,
	output logic [COUNT_BITS-1:0]      fin_sents,
	output logic [rts_pkg::SYL_W-1:0]  fin_syl
);
	import rts_pkg::*;

	logic [COUNT_BITS-1:0] lines_q, words_q, chars_q, sents_q;
	logic [SYL_W-1:0]      syl_q;
	logic [GROUP_W-1:0]    groups_q;
	logic                  active_q, letters_q, prevv_q, ends_e_q;
	logic                  punct_q, line_text_q;

	logic [COUNT_BITS-1:0] lines_n, words_n, chars_n, sents_n;
	logic [SYL_W-1:0]      syl_n;
	logic [GROUP_W-1:0]    groups_n;
	logic                  active_n, letters_n, prevv_n, ends_e_n;
	logic                  punct_n, line_text_n;
	logic                  close_now;
	logic [GROUP_W-1:0]    word_syl;
	logic [SYL_W:0]        syl_sum;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	assign done_valid = !empty && head.last;
	assign pop        = !empty && (!head.last || done_ready);

	always_comb begin
		lines_n     = lines_q;
		words_n     = words_q;
		chars_n     = chars_q;
		sents_n     = sents_q;
		syl_n       = syl_q;
		groups_n    = groups_q;
		active_n    = active_q;
		letters_n   = letters_q;
		prevv_n     = prevv_q;
		ends_e_n    = ends_e_q;
		punct_n     = punct_q;
		line_text_n = line_text_q;
		word_syl    = '0;
		syl_sum     = '0;

		if (head.has_char) begin
			if (!head.space) begin
				chars_n     = sat_inc(chars_q);
				line_text_n = 1'b1;
			end
			if (head.newline) begin
				if (line_text_q) begin
					lines_n = sat_inc(lines_q);
				end
				line_text_n = 1'b0;
			end
			if (head.punct) begin
				if (!punct_q) begin
					sents_n = sat_inc(sents_q);
				end
				punct_n = 1'b1;
			end else begin
				punct_n = 1'b0;
			end
			// run flags and groups are zero whenever no run is open
			if (head.wordc) begin
				active_n  = 1'b1;
				letters_n = (letters_q || !active_q) && head.letter;
				if (head.vowel && !prevv_q && groups_q != '1) begin
					groups_n = groups_q + 1'b1;
				end
				prevv_n  = head.vowel;
				ends_e_n = head.is_e;
			end
		end

		close_now = (head.has_char && !head.wordc) || head.last;
		if (close_now) begin
			if (active_n && letters_n) begin
				word_syl = (ends_e_n && groups_n > GROUP_W'(1)) ? groups_n - 1'b1 : groups_n;
				if (word_syl == '0) begin
					word_syl = GROUP_W'(1);
				end
				words_n = sat_inc(words_n);
				syl_sum = {1'b0, syl_n} + (SYL_W+1)'(word_syl);
				syl_n   = syl_sum[SYL_W] ? '1 : syl_sum[SYL_W-1:0];
			end
			active_n  = 1'b0;
			letters_n = 1'b0;
			prevv_n   = 1'b0;
			ends_e_n  = 1'b0;
			groups_n  = '0;
		end

		// count a final line without a newline
		if (head.last && line_text_n) begin
			lines_n = sat_inc(lines_n);
		end
	end

	assign fin_lines = lines_n;
	assign fin_words = words_n;
	assign fin_chars = chars_n;
	assign fin_sents = sents_n;
	assign fin_syl   = syl_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q     <= '0;
			words_q     <= '0;
			chars_q     <= '0;
			sents_q     <= '0;
			syl_q       <= '0;
			groups_q    <= '0;
			active_q    <= 1'b0;
			letters_q   <= 1'b0;
			prevv_q     <= 1'b0;
			ends_e_q    <= 1'b0;
			punct_q     <= 1'b0;
			line_text_q <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				lines_q     <= '0;
				words_q     <= '0;
				chars_q     <= '0;
				sents_q     <= '0;
				syl_q       <= '0;
				groups_q    <= '0;
				active_q    <= 1'b0;
				letters_q   <= 1'b0;
				prevv_q     <= 1'b0;
				ends_e_q    <= 1'b0;
				punct_q     <= 1'b0;
				line_text_q <= 1'b0;
			end else begin
				lines_q     <= lines_n;
				words_q     <= words_n;
				chars_q     <= chars_n;
				sents_q     <= sents_n;
				syl_q       <= syl_n;
				groups_q    <= groups_n;
				active_q    <= active_n;
				letters_q   <= letters_n;
				prevv_q     <= prevv_n;
				ends_e_q    <= ends_e_n;
				punct_q     <= punct_n;
				line_text_q <= line_text_n;
			end
		end
	end
endmodule

/* sv/rts_score.sv */
module rts_score #(
	parameter int COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start_valid,
	output logic                      start_ready,
	input  logic [COUNT_BITS-1:0]     fin_lines,
	input  logic [COUNT_BITS-1:0]     fin_words,
	input  logic [COUNT_BITS-1:0]     fin_chars,
	input  logic [COUNT_BITS-1:0]     fin_sents,
	input  logic [rts_pkg::SYL_W-1:0] fin_syl,
	rts_out_if.source                 out_ch
);
	import rts_pkg::*;

	localparam int PW = 2*COUNT_BITS;
	localparam int YW = SYL_W + COUNT_BITS;
	localparam int NW = 2*COUNT_BITS + 40;
	localparam int CW = $clog2(NW+1);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SCALE, S_PREP, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t                state_q;
	logic                  sel_q;
	logic [COUNT_BITS-1:0] w_q, s_q;
	logic [SYL_W-1:0]      y_q;
	logic [PW-1:0]         sw_q, ww_q;
	logic [YW-1:0]         ys_q;
	logic [NW-1:0]         ep_q, en_q, gp_q, gn_q;
	logic [NW-1:0]         num_q, den_q, rem_q, quo_q;
	logic [CW-1:0]         cnt_q;
	logic [OUT_CNT_W-1:0]  lines_o_q, words_o_q, chars_o_q, sents_o_q;
	logic [EASE_W-1:0]     ease_q;
	logic [GRADE_W-1:0]    grade_q;

	logic [COUNT_BITS-1:0] s_adj;
	logic [NW-1:0]         pos, neg, dd, diff;
	logic [NW:0]           trial;
	logic                  take;

	function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[OUT_CNT_W-1:0];
	endfunction

	assign start_ready = (state_q == S_IDLE);
	assign s_adj = (fin_sents == '0 && fin_words != '0) ? COUNT_BITS'(1) : fin_sents;

	always_comb begin
		pos   = sel_q ? gp_q : ep_q;
		neg   = sel_q ? gn_q : en_q;
		dd    = sel_q ? NW'(sw_q) : NW'({sw_q, 1'b0});
		diff  = pos - neg;
		trial = {rem_q, num_q[NW-1]};
		take  = (trial >= {1'b0, den_q});
	end

	assign out_ch.valid             = (state_q == S_OUT);
	assign out_ch.nonblank_lines    = lines_o_q;
	assign out_ch.word_total        = words_o_q;
	assign out_ch.visible_chars     = chars_o_q;
	assign out_ch.sentence_total    = sents_o_q;
	assign out_ch.reading_ease_x100 = ease_q;
	assign out_ch.grade_level_x100  = grade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_valid) begin
						lines_o_q <= to_out(fin_lines);
						words_o_q <= to_out(fin_words);
						chars_o_q <= to_out(fin_chars);
						sents_o_q <= to_out(s_adj);
						w_q       <= fin_words;
						s_q       <= s_adj;
						y_q       <= fin_syl;
						ease_q    <= '0;
						grade_q   <= '0;
						sel_q     <= 1'b0;
						state_q   <= (fin_words == '0) ? S_OUT : S_MUL;
					end
				end
				S_MUL: begin
					sw_q    <= PW'(w_q) * PW'(s_q);
					ww_q    <= PW'(w_q) * PW'(w_q);
					ys_q    <= YW'(y_q) * YW'(s_q);
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					ep_q    <= NW'(sw_q) * NW'(EASE_BASE);
					en_q    <= NW'(ww_q) * NW'(EASE_WW) + NW'(ys_q) * NW'(EASE_YS);
					gp_q    <= NW'(ww_q) * NW'(GRADE_WW) + NW'(ys_q) * NW'(GRADE_YS);
					gn_q    <= NW'(sw_q) * NW'(GRADE_SW);
					state_q <= S_PREP;
				end
				S_PREP: begin
					// not positive: score is zero, skip the divide
					if (pos <= neg) begin
						quo_q   <= '0;
						state_q <= S_FIN;
					end else begin
						num_q   <= {diff[NW-2:0], 1'b0} + dd;
						den_q   <= {dd[NW-2:0], 1'b0};
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= CW'(NW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= take ? NW'(trial - {1'b0, den_q}) : trial[NW-1:0];
					quo_q <= {quo_q[NW-2:0], take};
					num_q <= {num_q[NW-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!sel_q) begin
						ease_q  <= (quo_q > NW'(EASE_TOP)) ? EASE_W'(EASE_TOP) : quo_q[EASE_W-1:0];
						sel_q   <= 1'b1;
						state_q <= S_PREP;
					end else begin
						grade_q <= (quo_q > NW'(GRADE_TOP)) ? GRADE_TOP : quo_q[GRADE_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import rts_pkg::*;

	localparam int CLK_HI_NS  = 4;
	localparam int CLK_LO_NS  = 4;
	localparam int RST_CYCLES = 5;
	// The scorer runs a bit-serial divide for each score; a long receiver
	// hold-off stalls everything on top of that, so allow plenty of slack.
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_LIMIT   = 6000;
	localparam int RANDOM_ITEMS = 1750;
	localparam longint unsigned COUNT_TOP = (64'd1 << OUT_CNT_W) - 1;

	// Code points of interest, grouped by class; the space list ends with three that are not blanks
	localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
	localparam logic [CP_W-1:0] CP_LOWER_E = 21'h000065;
	localparam logic [CP_W-1:0] CP_UPPER_E = 21'h000045;
	localparam logic [CP_W-1:0] TURKISH_CPS [12] = '{21'hC7, 21'hD6, 21'hDC, 21'hE7,
		21'hF6, 21'hFC, 21'h11E, 21'h11F, 21'h130, 21'h131, 21'h15E, 21'h15F};
	localparam logic [CP_W-1:0] UNI_SPACE_CPS [18] = '{21'h09, 21'h0B, 21'h0C, 21'h0D,
		21'h85, 21'hA0, 21'h1680, 21'h2000, 21'h2005, 21'h200A, 21'h2028, 21'h2029,
		21'h202F, 21'h205F, 21'h3000, 21'h1FFF, 21'h200B, 21'h1FFFFF};
	localparam logic [CP_W-1:0] VOWEL_CPS [12] = '{21'h61, 21'h65, 21'h69, 21'h6F,
		21'h75, 21'h79, 21'h41, 21'h45, 21'h49, 21'h4F, 21'h55, 21'h59};

	typedef struct packed {
		logic [OUT_CNT_W-1:0] lines;
		logic [OUT_CNT_W-1:0] words;
		logic [OUT_CNT_W-1:0] chars;
		logic [OUT_CNT_W-1:0] sentences;
		logic [EASE_W-1:0]    ease;
		logic [GRADE_W-1:0]   grade;
	} text_score_t;

	logic clk;
	logic arst_n;
	int   error_count;
	bit   stimulus_done;
	bit   receiver_hold;

	rts_in_if  in_ch ();
	rts_out_if out_ch ();

	readability_text_stats dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// One line per mismatch; the final verdict uses the count
	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Running tally of the text so far plus the queue of scores still owed by the block
	class text_scoreboard;
		longint unsigned line_cnt, word_cnt, char_cnt, sent_cnt, syl_sum, groups;
		bit run_active, run_letters, prev_vowel, ends_e, in_punct, line_has_text;
		text_score_t owed_scores[$];

		function new();
			clear_text();
		endfunction

		function void clear_text();
			line_cnt = 0; word_cnt = 0; char_cnt = 0; sent_cnt = 0;
			syl_sum = 0; groups = 0;
			run_active = 0; run_letters = 0; prev_vowel = 0; ends_e = 0;
			in_punct = 0; line_has_text = 0;
		endfunction

		function bit is_blank(logic [CP_W-1:0] c);
			return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 ||
				c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
				c == 21'h2028 || c == 21'h2029 || c == 21'h202F || c == 21'h205F ||
				c == 21'h3000;
		endfunction

		function bit is_alpha(logic [CP_W-1:0] c);
			if ((c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A))
				return 1;
			foreach (TURKISH_CPS[i])
				if (c == TURKISH_CPS[i])
					return 1;
			return 0;
		endfunction

		function bit is_vowel(logic [CP_W-1:0] c);
			foreach (VOWEL_CPS[i])
				if (c == VOWEL_CPS[i])
					return 1;
			return c == CP_DOT_I_CAP;
		endfunction

		function longint unsigned bump(longint unsigned v, longint unsigned top);
			return (v < top) ? v + 1 : top;
		endfunction

		function void end_word();
			longint unsigned syl;
			if (run_active && run_letters) begin
				syl = groups;
				if (ends_e && syl > 1)
					syl--;
				if (syl < 1)
					syl = 1;
				word_cnt = bump(word_cnt, COUNT_TOP);
				syl_sum += syl;
				if (syl_sum > 64'hFFFF_FFFF)
					syl_sum = 64'hFFFF_FFFF;
			end
			run_active = 0; run_letters = 0; prev_vowel = 0; ends_e = 0;
			groups = 0;
		endfunction

		function void add_char(logic [CP_W-1:0] c);
			bit alpha, wordc, vow;
			alpha = is_alpha(c);
			wordc = alpha || (c >= 21'h30 && c <= 21'h39) || c == CP_UNDERSCORE;
			if (!is_blank(c)) begin
				char_cnt = bump(char_cnt, COUNT_TOP);
				line_has_text = 1;
			end
			if (c == CP_NEWLINE) begin
				if (line_has_text)
					line_cnt = bump(line_cnt, COUNT_TOP);
				line_has_text = 0;
			end
			if (c == CP_FULL_STOP || c == CP_EXCLAIM || c == CP_QUESTION) begin
				if (!in_punct)
					sent_cnt = bump(sent_cnt, COUNT_TOP);
				in_punct = 1;
			end else begin
				in_punct = 0;
			end
			if (wordc) begin
				vow = is_vowel(c);
				if (!run_active) begin
					run_active = 1; run_letters = 1; groups = 0;
				end
				if (!alpha)
					run_letters = 0;
				if (vow && !prev_vowel)
					groups = bump(groups, 64'hFFFF);
				prev_vowel = vow;
				ends_e = (c == CP_LOWER_E || c == CP_UPPER_E);
			end else begin
				end_word();
			end
		endfunction

		// (pos - neg) / d rounded half up, zero when not positive, capped at top
		function longint unsigned round_ratio(logic [127:0] pos, logic [127:0] neg,
				logic [127:0] d, longint unsigned top);
			logic [127:0] q;
			if (pos <= neg)
				return 0;
			q = (2 * (pos - neg) + d) / (2 * d);
			return (q > top) ? top : q[63:0];
		endfunction

		function text_score_t score_text();
			text_score_t r;
			longint unsigned s;
			logic [127:0] d, ww, ys;
			end_word();
			if (line_has_text)
				line_cnt = bump(line_cnt, COUNT_TOP);
			s = (sent_cnt == 0 && word_cnt > 0) ? 1 : sent_cnt;
			r.lines     = line_cnt[OUT_CNT_W-1:0];
			r.words     = word_cnt[OUT_CNT_W-1:0];
			r.chars     = char_cnt[OUT_CNT_W-1:0];
			r.sentences = s[OUT_CNT_W-1:0];
			r.ease      = '0;
			r.grade     = '0;
			if (word_cnt > 0) begin
				d  = 128'(s) * 128'(word_cnt);
				ww = 128'(word_cnt) * 128'(word_cnt);
				ys = 128'(syl_sum) * 128'(s);
				r.ease = EASE_W'(round_ratio(d * EASE_BASE, ww * EASE_WW + ys * EASE_YS,
					2 * d, EASE_TOP));
				r.grade = GRADE_W'(round_ratio(ww * GRADE_WW + ys * GRADE_YS,
					d * GRADE_SW, d, 64'hFFFF_FFFF));
			end
			clear_text();
			return r;
		endfunction

		function void note_input(logic [CP_W-1:0] cp, logic has_char, logic last);
			if (has_char)
				add_char(cp);
			if (last)
				owed_scores.push_back(score_text());
		endfunction

		task check_score(text_score_t got);
			text_score_t exp;
			if (owed_scores.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
				return;
			end
			exp = owed_scores.pop_front();
			if (got.lines !== exp.lines)
				report_mismatch($sformatf("nonblank_lines %0d, want %0d", got.lines, exp.lines));
			if (got.words !== exp.words)
				report_mismatch($sformatf("word_total %0d, want %0d", got.words, exp.words));
			if (got.chars !== exp.chars)
				report_mismatch($sformatf("visible_chars %0d, want %0d", got.chars, exp.chars));
			if (got.sentences !== exp.sentences)
				report_mismatch($sformatf("sentence_total %0d, want %0d",
					got.sentences, exp.sentences));
			if (got.ease !== exp.ease)
				report_mismatch($sformatf("reading_ease_x100 %0d, want %0d", got.ease, exp.ease));
			if (got.grade !== exp.grade)
				report_mismatch($sformatf("grade_level_x100 %0d, want %0d",
					got.grade, exp.grade));
		endtask
	endclass

	text_scoreboard scores = new();

	// Clock and a single reset at the start
	initial clk = 1'b0;
	always begin
		#CLK_LO_NS clk = 1'b1;
		#CLK_HI_NS clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Idle lengths: mostly short, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	// Hold the item on the channel until it transfers; leave valid high so the
	// next item can follow back to back.
	task automatic send_item(input logic [CP_W-1:0] cp, input logic has_char,
			input logic last);
		in_ch.valid    <= 1'b1;
		in_ch.code_point <= cp;
		in_ch.has_char <= has_char;
		in_ch.last     <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		scores.note_input(cp, has_char, last);
	endtask

	task automatic pause_sender(input int cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_string(input string txt, input bit end_here);
		for (int i = 0; i < txt.len(); i++)
			send_item(CP_W'(txt[i]), 1'b1, end_here && i == txt.len() - 1);
	endtask

	// Draw one character, weighted towards text that forms real words
	function automatic logic [CP_W-1:0] pick_char();
		case ($urandom_range(0, 24))
			0, 1, 2, 3: return CP_W'($urandom_range(8'h61, 8'h7A));
			4:          return CP_W'($urandom_range(8'h41, 8'h5A));
			5, 6, 7:    return VOWEL_CPS[$urandom_range(0, 11)];
			8:          return CP_LOWER_E;
			9:          return CP_UPPER_E;
			10:         return TURKISH_CPS[$urandom_range(0, 11)];
			11:         return CP_W'($urandom_range(8'h30, 8'h39));
			12:         return CP_UNDERSCORE;
			13, 14, 15: return CP_SPACE;
			16:         return CP_NEWLINE;
			17:         return CP_FULL_STOP;
			18:         return $urandom_range(0, 1) ? CP_EXCLAIM : CP_QUESTION;
			19:         return UNI_SPACE_CPS[$urandom_range(0, 17)];
			20:         return CP_W'($urandom_range(0, 255));
			21:         return CP_W'($urandom_range(0, 21'h1FFFFF));
			default:    return CP_W'($urandom_range(21'h100, 21'h3100));
		endcase
	endfunction

	// Stimulus
	initial begin
		int sent;
		int text_len;
		logic [CP_W-1:0] cp;
		bit hold_asked;
		bit drain_done;
		in_ch.valid      <= 1'b0;
		in_ch.code_point <= '0;
		in_ch.has_char   <= 1'b0;
		in_ch.last       <= 1'b0;
		stimulus_done = 0;
		hold_asked = 0;
		drain_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Empty text, then whitespace only
		send_item('0, 1'b0, 1'b1);
		send_string(" \t\n", 0);
		send_item('0, 1'b0, 1'b1);
		// Plain sentences, a final silent e, a lone e and a run of punctuation
		send_string("The cake is nice. Be quick?!\n", 0);
		send_item('0, 1'b0, 1'b0);
		send_string("e bay", 1);
		// Words spoiled by a digit or underscore; words but no full stop
		send_string("ab1 x_y queue", 1);
		// Turkish letters, dotted capital I as a vowel, extremes of the code point
		send_item(21'h130, 1'b1, 1'b0);
		send_item(21'h15F, 1'b1, 1'b0);
		send_item(21'h1FFFFF, 1'b1, 1'b0);
		send_item(21'h000000, 1'b1, 1'b0);
		send_item(21'h3000, 1'b1, 1'b1);
		pause_sender(pick_gap());

		// Random texts; mostly well formed, with noise and stray markers
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// Once early on, let the receiver hold off while the input backs up
			if (sent > 200 && !hold_asked) begin
				hold_asked = 1;
				receiver_hold = 1;
			end
			// Once, wait for every owed score before starting the next text
			if (sent > 900 && !drain_done) begin
				drain_done = 1;
				in_ch.valid <= 1'b0;
				while (scores.owed_scores.size() != 0)
					@(posedge clk);
			end
			text_len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 30);
			for (int i = 0; i < text_len; i++) begin
				cp = pick_char();
				if ($urandom_range(0, 29) == 0)
					send_item(cp, 1'b0, 1'b0);
				else
					send_item(cp, 1'b1, 1'b0);
				sent++;
				if ($urandom_range(0, 5) == 0)
					pause_sender(pick_gap());
			end
			// End marker either carries a final character or stands bare
			send_item(pick_char(), 1'($urandom_range(0, 1)), 1'b1);
			sent++;
			if ($urandom_range(0, 2) == 0)
				pause_sender(pick_gap());
		end
		in_ch.valid <= 1'b0;
		stimulus_done = 1;
	end

	// Receiver: random readiness, one long hold-off when asked
	initial begin
		out_ch.ready <= 1'b0;
		receiver_hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold == 1) begin
				out_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				receiver_hold = 0;
			end
			if ($urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Check each result transfer
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			scores.check_score('{out_ch.nonblank_lines, out_ch.word_total,
				out_ch.visible_chars, out_ch.sentence_total,
				out_ch.reading_ease_x100, out_ch.grade_level_x100});
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Drain, let any late result show up, then give the verdict
	initial begin
		wait (stimulus_done == 1);
		while (scores.owed_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
